// File: sv/brlh_pkg.sv
// Shared types and constants for the bit run-length histogram unit.
`timescale 1ns / 1ps
`default_nettype none

package brlh_pkg;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_NEXT  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [5:0]         THRESH_RESET = 6'd10;
  localparam logic [6:0]         RUN_MAX      = 7'd64;
  localparam logic signed [31:0] SCORE_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SCORE_MIN    = 32'sh8000_0000;
  localparam logic [31:0]        COUNT_MAX    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] action;
    logic       bit_value;
    logic [5:0] bin_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        zero_runs_count;
    logic [31:0]        one_runs_count;
    logic [6:0]         open_run;
    logic signed [31:0] trial_score;
    logic signed [31:0] overall_score;
    logic [31:0]        guess_count;
  } out_word_t;

endpackage

`default_nettype wire

// File: sv/bit_run_length_histogram_unit.sv
// Run-length histogram of a bit stream with a streak-flip predictor score.
//
// Input words carry an action: start a trial with a bit, feed the next bit,
// or read one histogram bin. Every accepted word yields exactly one output
// word with the bin counts (reads only) and the run/score/guess status.
// cfg_we/cfg_wdata set the streak threshold; write only while idle.
// Both channels move a word on a clock edge with valid high and stall low.
// Output words are registered in the read stage, then in the output queue.
// Throughput: one word per cycle while in_stall is low. The two histograms
// sit in one-port-read, one-port-write memories; a finished run is counted
// by read-modify-write; a word that hits the bin being written in the same
// cycle takes the new count by forwarding, so back-to-back runs never stall.
// A three-entry output queue decouples the sides: in_stall rises only when
// the queue plus the word in flight fill it, i.e. after out_stall has held.
// Reset (rst_n low, synchronous) clears status, threshold to 10, and the
// per-bin valid flags, so both histograms read as zero at once.
`timescale 1ns / 1ps
`default_nettype none

module bit_run_length_histogram_unit
  import brlh_pkg::*;
#(
  parameter int NUM_BINS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word,
  input  wire logic      cfg_we,
  input  wire logic [5:0] cfg_wdata
);

  localparam int BIN_AW   = $clog2(NUM_BINS);
  localparam int OQ_DEPTH = 3;

  // configuration and scalar state
  logic [5:0]         thresh_r;
  logic               last_bit_r, last_bit_nxt;
  logic [6:0]         run_r, run_nxt;
  logic               trial_open_r, trial_open_nxt;
  logic signed [31:0] trial_score_r, trial_score_nxt;
  logic signed [31:0] overall_score_r, overall_score_nxt;
  logic [31:0]        guesses_r, guesses_nxt;

  // histogram memories and per-bin valid flags
  logic [31:0]       zero_mem [NUM_BINS];
  logic [31:0]       one_mem  [NUM_BINS];
  logic [NUM_BINS-1:0] zero_vld_r, one_vld_r;

  // read stage
  logic [31:0] rd_zero_r, rd_one_r;
  logic        rdv_zero_r, rdv_one_r;
  logic        fwd_zero_r, fwd_one_r, fwd_zero_nxt, fwd_one_nxt;
  logic [31:0] fwd_data_r;

  logic              s1_v_r;
  logic              s1_inc_r, s1_inc_nxt;
  logic              s1_sel_one_r, s1_sel_one_nxt;
  logic              s1_rd_r, s1_rd_nxt;
  logic [BIN_AW-1:0] s1_addr_r, s1_addr_nxt;
  out_word_t         s1_word_r, s1_word_nxt;

  logic [31:0] eff_zero, eff_one, inc_cur, inc_val;
  out_word_t   done_word;
  logic        wr_zero, wr_one;

  // output queue
  out_word_t oq_r [OQ_DEPTH];
  logic [1:0] oq_wp_r, oq_rp_r, oq_cnt_r, oq_cnt_nxt;
  logic       push, pop;

  logic       accept;
  logic       is_start, is_next, guess, flip;
  logic [7:0] bin_ext;

  assign accept = in_valid && !in_stall;
  assign in_stall = (3'(oq_cnt_r) + 3'(s1_v_r)) >= 3'(OQ_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  // status update and memory request for the incoming word
  always_comb begin
    is_start = (in_word.action == ACT_START) ||
               (in_word.action == ACT_NEXT && !trial_open_r);
    is_next  = (in_word.action == ACT_NEXT) && trial_open_r;
    guess    = is_next && (run_r >= {1'b0, thresh_r});
    flip     = in_word.bit_value != last_bit_r;

    last_bit_nxt      = last_bit_r;
    run_nxt           = run_r;
    trial_open_nxt    = trial_open_r;
    trial_score_nxt   = trial_score_r;
    overall_score_nxt = overall_score_r;
    guesses_nxt       = guesses_r;

    if (guess) begin
      if (flip) begin
        trial_score_nxt = (trial_score_r == SCORE_MAX) ? trial_score_r : trial_score_r + 1;
        overall_score_nxt = (overall_score_r == SCORE_MAX) ? overall_score_r :
                            overall_score_r + 1;
      end else begin
        trial_score_nxt = (trial_score_r == SCORE_MIN) ? trial_score_r : trial_score_r - 1;
        overall_score_nxt = (overall_score_r == SCORE_MIN) ? overall_score_r :
                            overall_score_r - 1;
      end
      guesses_nxt = (guesses_r == COUNT_MAX) ? guesses_r : guesses_r + 32'd1;
    end

    if (is_start) begin
      last_bit_nxt    = in_word.bit_value;
      run_nxt         = 7'd1;
      trial_open_nxt  = 1'b1;
      trial_score_nxt = '0;
    end else if (is_next) begin
      last_bit_nxt = in_word.bit_value;
      if (flip) begin
        run_nxt = 7'd1;
      end else if (run_r < RUN_MAX) begin
        run_nxt = run_r + 7'd1;
      end
    end

    // a finished run counts into its bin, long runs into the last bin
    bin_ext        = {2'b00, in_word.bin_index};
    s1_inc_nxt     = is_next && flip;
    s1_sel_one_nxt = last_bit_r;
    s1_rd_nxt      = (in_word.action == ACT_READ) && (9'(bin_ext) < 9'(NUM_BINS));
    if (in_word.action == ACT_READ) begin
      s1_addr_nxt = bin_ext[BIN_AW-1:0];
    end else if (9'(run_r) < 9'(NUM_BINS - 1)) begin
      s1_addr_nxt = BIN_AW'(run_r);
    end else begin
      s1_addr_nxt = BIN_AW'(NUM_BINS - 1);
    end

    s1_word_nxt.zero_runs_count = '0;
    s1_word_nxt.one_runs_count  = '0;
    s1_word_nxt.open_run        = run_nxt;
    s1_word_nxt.trial_score     = trial_score_nxt;
    s1_word_nxt.overall_score   = overall_score_nxt;
    s1_word_nxt.guess_count     = guesses_nxt;

    // the word in flight writes this cycle: hand its count straight over
    fwd_zero_nxt = wr_zero && (s1_addr_r == s1_addr_nxt);
    fwd_one_nxt  = wr_one && (s1_addr_r == s1_addr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_bit_r      <= 1'b0;
      run_r           <= '0;
      trial_open_r    <= 1'b0;
      trial_score_r   <= '0;
      overall_score_r <= '0;
      guesses_r       <= '0;
      s1_v_r          <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (accept) begin
        last_bit_r      <= last_bit_nxt;
        run_r           <= run_nxt;
        trial_open_r    <= trial_open_nxt;
        trial_score_r   <= trial_score_nxt;
        overall_score_r <= overall_score_nxt;
        guesses_r       <= guesses_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_inc_r     <= s1_inc_nxt;
    s1_sel_one_r <= s1_sel_one_nxt;
    s1_rd_r      <= s1_rd_nxt;
    s1_addr_r    <= s1_addr_nxt;
    s1_word_r    <= s1_word_nxt;
    rdv_zero_r   <= zero_vld_r[s1_addr_nxt];
    rdv_one_r    <= one_vld_r[s1_addr_nxt];
    fwd_zero_r   <= fwd_zero_nxt;
    fwd_one_r    <= fwd_one_nxt;
    fwd_data_r   <= inc_val;
  end

  // read-modify-write stage
  always_comb begin
    eff_zero = fwd_zero_r ? fwd_data_r : (rdv_zero_r ? rd_zero_r : '0);
    eff_one  = fwd_one_r ? fwd_data_r : (rdv_one_r ? rd_one_r : '0);
    inc_cur  = s1_sel_one_r ? eff_one : eff_zero;
    inc_val  = (inc_cur == COUNT_MAX) ? inc_cur : inc_cur + 32'd1;
    wr_zero  = s1_v_r && s1_inc_r && !s1_sel_one_r;
    wr_one   = s1_v_r && s1_inc_r && s1_sel_one_r;

    done_word = s1_word_r;
    if (s1_rd_r) begin
      done_word.zero_runs_count = eff_zero;
      done_word.one_runs_count  = eff_one;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_zero) begin
      zero_mem[s1_addr_r] <= inc_val;
    end
    rd_zero_r <= zero_mem[s1_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (wr_one) begin
      one_mem[s1_addr_r] <= inc_val;
    end
    rd_one_r <= one_mem[s1_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_vld_r <= '0;
      one_vld_r  <= '0;
    end else begin
      if (wr_zero) zero_vld_r[s1_addr_r] <= 1'b1;
      if (wr_one)  one_vld_r[s1_addr_r]  <= 1'b1;
    end
  end

  // output queue
  assign push      = s1_v_r;
  assign out_valid = oq_cnt_r != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign out_word  = oq_r[oq_rp_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (push && !pop) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (pop && !push) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (push) oq_wp_r <= (oq_wp_r == 2'(OQ_DEPTH - 1)) ? 2'd0 : oq_wp_r + 2'd1;
      if (pop)  oq_rp_r <= (oq_rp_r == 2'(OQ_DEPTH - 1)) ? 2'd0 : oq_rp_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_r[oq_wp_r] <= done_word;
    end
  end

endmodule

`default_nettype wire

// File: sim/bit_run_length_histogram_unit_test.sv
// Self-checking testbench for the bit run-length histogram unit.
`timescale 1ns / 1ps

module bit_run_length_histogram_unit_test;
  import brlh_pkg::*;

  localparam int         BIN_COUNT  = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         HOLD_LEN   = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_we    = 1'b0;
  logic [5:0] cfg_wdata = '0;

  // stimulus control
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_on        = 1'b0;
  int   mismatch_count = 0;

  in_word_t  stream_words[$];
  out_word_t predicted_status[$];
  out_word_t status_want;

  // predictor state
  logic               cur_bit      = 1'b0;
  logic [6:0]         open_len     = '0;
  logic               trial_live   = 1'b0;
  logic [31:0]        zero_hist[BIN_COUNT];
  logic [31:0]        one_hist[BIN_COUNT];
  logic signed [31:0] trial_points = '0;
  logic signed [31:0] total_points = '0;
  logic [31:0]        guess_total  = '0;
  logic [5:0]         streak_limit = THRESH_RESET;

  bit_run_length_histogram_unit #(.NUM_BINS(BIN_COUNT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic signed [31:0] score_step(logic signed [31:0] s, logic flipped);
    if (flipped) begin
      return (s == SCORE_MAX) ? s : s + 32'sd1;
    end
    return (s == SCORE_MIN) ? s : s - 32'sd1;
  endfunction

  function automatic logic [31:0] count_bump(logic [31:0] c);
    return (c == COUNT_MAX) ? c : c + 32'd1;
  endfunction

  // Advances the predictor by one word and returns the status word it yields.
  function automatic out_word_t histogram_predict(in_word_t w);
    out_word_t  r;
    logic       flipped;
    logic [5:0] idx;
    r = '0;
    if (w.action == ACT_START || (w.action == ACT_NEXT && !trial_live)) begin
      cur_bit      = w.bit_value;
      open_len     = 7'd1;
      trial_live   = 1'b1;
      trial_points = '0;
    end else if (w.action == ACT_NEXT) begin
      if (open_len >= {1'b0, streak_limit}) begin
        flipped      = (w.bit_value != cur_bit);
        trial_points = score_step(trial_points, flipped);
        total_points = score_step(total_points, flipped);
        guess_total  = count_bump(guess_total);
      end
      if (w.bit_value == cur_bit) begin
        if (open_len < RUN_MAX) open_len = open_len + 7'd1;
      end else begin
        // long runs all land in the top bin
        idx = (open_len < 7'(BIN_COUNT - 1)) ? open_len[5:0] : 6'(BIN_COUNT - 1);
        if (cur_bit) one_hist[idx] = count_bump(one_hist[idx]);
        else zero_hist[idx] = count_bump(zero_hist[idx]);
        open_len = 7'd1;
      end
      cur_bit = w.bit_value;
    end else if (w.action == ACT_READ && w.bin_index < BIN_COUNT) begin
      r.zero_runs_count = zero_hist[w.bin_index];
      r.one_runs_count  = one_hist[w.bin_index];
    end
    r.open_run      = open_len;
    r.trial_score   = trial_points;
    r.overall_score = total_points;
    r.guess_count   = guess_total;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100) begin
      $display("%0t ns: %s mismatch: got 0x%08h, expected 0x%08h", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_status.push_back(histogram_predict(in_word));
      if (!in_valid || !in_stall) begin
        if (stream_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word  <= stream_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_status.size() == 0) begin
          report_mismatch("unexpected word, open_run", 32'(out_word.open_run), '0);
        end else begin
          status_want = predicted_status.pop_front();
          if (out_word.zero_runs_count !== status_want.zero_runs_count)
            report_mismatch("zero_runs_count", out_word.zero_runs_count,
                            status_want.zero_runs_count);
          if (out_word.one_runs_count !== status_want.one_runs_count)
            report_mismatch("one_runs_count", out_word.one_runs_count,
                            status_want.one_runs_count);
          if (out_word.open_run !== status_want.open_run)
            report_mismatch("open_run", 32'(out_word.open_run), 32'(status_want.open_run));
          if (out_word.trial_score !== status_want.trial_score)
            report_mismatch("trial_score", out_word.trial_score, status_want.trial_score);
          if (out_word.overall_score !== status_want.overall_score)
            report_mismatch("overall_score", out_word.overall_score,
                            status_want.overall_score);
          if (out_word.guess_count !== status_want.guess_count)
            report_mismatch("guess_count", out_word.guess_count, status_want.guess_count);
        end
      end
      out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_word(input logic [1:0] act, input logic b, input logic [5:0] bin);
    in_word_t w;
    w.action    = act;
    w.bit_value = b;
    w.bin_index = bin;
    stream_words.push_back(w);
  endtask

  // Mostly runs of equal bits with random lengths, plus trial restarts,
  // bin reads and the odd unused action.
  task automatic queue_random_stream(input int target);
    int   made;
    int   run;
    int   pick;
    logic b;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        b = 1'($urandom_range(1));
        case ($urandom_range(9))
          0:       run = $urandom_range(75, 31);
          1, 2:    run = $urandom_range(30, 9);
          default: run = $urandom_range(8, 1);
        endcase
        if (run > target - made) run = target - made;
        repeat (run) queue_word(ACT_NEXT, b, 6'($urandom_range(63)));
        made += run;
      end else if (pick < 80) begin
        queue_word(ACT_START, 1'($urandom_range(1)), 6'($urandom_range(63)));
        made++;
      end else if (pick < 97) begin
        queue_word(ACT_READ, 1'($urandom_range(1)),
                   $urandom_range(1) ? 6'($urandom_range(15)) : 6'($urandom_range(63)));
        made++;
      end else if (pick < 99) begin
        queue_word(ACT_NEXT, 1'($urandom_range(1)), 6'($urandom_range(63)));
        made++;
      end else begin
        queue_word(ACT_UNUSED, 1'($urandom_range(1)), 6'($urandom_range(63)));
      end
    end
  endtask

  task automatic wait_all_done();
    while (stream_words.size() != 0 || in_valid || predicted_status.size() != 0)
      @(posedge clk);
  endtask

  // threshold writes go in only once the pipe is empty
  task automatic write_threshold(input logic [5:0] value);
    wait_all_done();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    streak_limit = value;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  initial begin
    for (int i = 0; i < BIN_COUNT; i++) begin
      zero_hist[i] = '0;
      one_hist[i]  = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, unused action, next bit with no trial open,
    // a binned ones run, a restart that drops the open run unbinned
    queue_word(ACT_READ, 1'b1, 6'd0);
    queue_word(ACT_READ, 1'b0, 6'd63);
    queue_word(ACT_UNUSED, 1'b1, 6'h3F);
    queue_word(ACT_NEXT, 1'b1, 6'h2A);
    queue_word(ACT_NEXT, 1'b1, 6'h15);
    queue_word(ACT_NEXT, 1'b1, 6'h3F);
    queue_word(ACT_NEXT, 1'b0, 6'h00);
    queue_word(ACT_NEXT, 1'b0, 6'h3F);
    queue_word(ACT_NEXT, 1'b0, 6'h01);
    queue_word(ACT_START, 1'b1, 6'h3F);
    queue_word(ACT_NEXT, 1'b0, 6'h20);
    queue_word(ACT_READ, 1'b1, 6'd3);
    queue_word(ACT_READ, 1'b0, 6'd1);
    queue_word(ACT_READ, 1'b1, 6'd2);
    queue_word(ACT_UNUSED, 1'b0, 6'h00);
    queue_word(ACT_START, 1'b0, 6'h00);
    queue_random_stream(107);

    write_threshold(6'd1);
    set_idling(87, 0);
    queue_random_stream(107);

    write_threshold(6'd63);
    set_idling(0, 87);
    queue_random_stream(107);

    write_threshold(6'd0);
    set_idling(17, 17);
    queue_random_stream(107);

    // back-pressure: receiver holds off while the sender keeps offering
    write_threshold(6'($urandom_range(12, 2)));
    set_idling(0, 0);
    queue_random_stream(107);
    fork
      begin
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none

    wait_all_done();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
